>>> rtl/core/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg - shared types and codes of the request/response tracker
// Operation codes, mode encoding, status codes and the command/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrt_pkg;

    // operation codes on the op port
    localparam logic [2:0] OP_INIT     = 3'd0;
    localparam logic [2:0] OP_SEND     = 3'd1;
    localparam logic [2:0] OP_ACK      = 3'd2;
    localparam logic [2:0] OP_WAIT     = 3'd3;
    localparam logic [2:0] OP_INCOMING = 3'd4;
    localparam logic [2:0] OP_COLLECT  = 3'd5;
    localparam logic [2:0] OP_RESET    = 3'd6;

    // status codes
    localparam logic [3:0] ST_NONE        = 4'd0;
    localparam logic [3:0] ST_NOTREADY    = 4'd1;
    localparam logic [3:0] ST_BUSY        = 4'd2;
    localparam logic [3:0] ST_INTERNAL    = 4'd3;
    localparam logic [3:0] ST_UNSOLICITED = 4'd4;
    localparam logic [3:0] ST_WAITING     = 4'd5;
    localparam logic [3:0] ST_UNHANDLED   = 4'd6;

    // answered counter width and its saturation value
    localparam int         ANS_W   = 4;
    localparam logic [3:0] ANS_MAX = 4'd15;

    typedef enum logic [2:0] {
        MODE_STARTUP = 3'd0,
        MODE_INIT    = 3'd1,
        MODE_SENT    = 3'd2,
        MODE_WAIT    = 3'd3,
        MODE_RECV    = 3'd4
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the accepted beat and arm the scan
        logic step;     // visit one table entry
        logic finish;   // apply the event and register the result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;  // the offered beat needs a table walk
        logic scan_last;  // the current entry is the last one to visit
    } stat_t;

endpackage

>>> rtl/core/rrt_ctrl.sv
// ----------------------------------------------------------------------------
// rrt_ctrl - sequencer of the request/response tracker
// Accepts a beat, walks the table one entry per cycle when needed, then
// finishes the event.
// ----------------------------------------------------------------------------
module rrt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rrt_pkg::stat_t stat,
    output rrt_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

endmodule

>>> rtl/core/rrt_datapath.sv
// ----------------------------------------------------------------------------
// rrt_datapath - table, counters and result registers of the tracker
// Holds the awaited-type table, mode and counters; searches and compacts the
// table one entry per step and registers the result of each event.
// ----------------------------------------------------------------------------
module rrt_datapath #(
    parameter int MAX_PENDING = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rrt_pkg::cmd_t  cmd,
    output rrt_pkg::stat_t stat,
    input  logic [2:0]     op,
    input  logic [7:0]     msg_type,
    input  logic [7:0]     context_tag,
    input  logic           handled,
    input  logic [3:0]     handler_code,
    output logic           done,
    output logic [3:0]     status,
    output logic [2:0]     mode_now,
    output logic           send_strobe,
    output logic           matched,
    output logic [7:0]     matched_tag,
    output logic           default_route,
    output logic           dump_request,
    output logic [7:0]     last_sent_type
);

    localparam int CW = $clog2(MAX_PENDING + 1);
    localparam int IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int KW = (CW > rrt_pkg::ANS_W) ? CW : rrt_pkg::ANS_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PENDING);

    // table
    logic [7:0] type_mem [MAX_PENDING];
    logic [7:0] tag_mem  [MAX_PENDING];
    logic [3:0] code_mem [MAX_PENDING];

    // architectural state
    rrt_pkg::mode_t          mode_reg, mode_next;
    logic [CW-1:0]           pending_reg, pending_next;
    logic [rrt_pkg::ANS_W-1:0] answered_reg, answered_next;
    logic [7:0]              sent_reg, sent_next;

    // captured beat
    logic [2:0] op_reg, op_next;
    logic [7:0] msg_reg, msg_next;
    logic [7:0] tag_reg, tag_next;
    logic       handled_reg, handled_next;
    logic [3:0] hcode_reg, hcode_next;

    // walk state
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] n_reg, n_next;
    logic [3:0]    err_reg, err_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [7:0]    hit_tag_reg, hit_tag_next;

    // result registers
    logic       done_reg, done_next;
    logic [3:0] status_reg, status_next;
    logic       send_reg, send_next;
    logic       matched_reg, matched_next;
    logic [7:0] mtag_reg, mtag_next;
    logic       droute_reg, droute_next;
    logic       dump_reg, dump_next;

    // table write port
    logic          we_all;
    logic          we_code;
    logic [IW-1:0] waddr;
    logic [7:0]    wtype;
    logic [7:0]    wtag;
    logic [3:0]    wcode;

    logic [7:0] rd_type;
    logic [7:0] rd_tag;
    logic [3:0] rd_code;
    logic [3:0] inc_res;
    logic [rrt_pkg::ANS_W-1:0] ans_inc;
    logic [KW-1:0] ans_ext;
    logic [CW-1:0] scan_n;

    assign rd_type = type_mem[idx_reg];
    assign rd_tag  = tag_mem[idx_reg];
    assign rd_code = code_mem[idx_reg];

    assign inc_res = handled_reg ? hcode_reg : rrt_pkg::ST_INTERNAL;
    assign ans_inc = (answered_reg != rrt_pkg::ANS_MAX) ? answered_reg + 1'b1 : answered_reg;

    // collect walks the answered entries, clamped to the table depth
    assign ans_ext = KW'(answered_reg);
    assign scan_n  = (op == rrt_pkg::OP_COLLECT)
                   ? ((ans_ext < KW'(MAX_PENDING)) ? CW'(ans_ext) : MAX_CNT)
                   : pending_reg;

    assign stat.need_scan =
        ((op == rrt_pkg::OP_INCOMING) && (mode_reg == rrt_pkg::MODE_WAIT)
            && (pending_reg != '0))
        || ((op == rrt_pkg::OP_COLLECT) && (mode_reg == rrt_pkg::MODE_RECV)
            && (answered_reg != '0));
    assign stat.scan_last = ((CW'(idx_reg) + CW'(1)) == n_reg);

    always_comb
    begin
        mode_next     = mode_reg;
        pending_next  = pending_reg;
        answered_next = answered_reg;
        sent_next     = sent_reg;
        op_next       = op_reg;
        msg_next      = msg_reg;
        tag_next      = tag_reg;
        handled_next  = handled_reg;
        hcode_next    = hcode_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        rem_next      = rem_reg;
        n_next        = n_reg;
        err_next      = err_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_tag_next  = hit_tag_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        send_next     = send_reg;
        matched_next  = matched_reg;
        mtag_next     = mtag_reg;
        droute_next   = droute_reg;
        dump_next     = dump_reg;
        we_all        = 1'b0;
        we_code       = 1'b0;
        waddr         = '0;
        wtype         = rd_type;
        wtag          = rd_tag;
        wcode         = rd_code;

        if (cmd.load)
        begin
            op_next      = op;
            msg_next     = msg_type;
            tag_next     = context_tag;
            handled_next = handled;
            hcode_next   = handler_code;
            idx_next     = '0;
            wr_next      = '0;
            rem_next     = '0;
            n_next       = scan_n;
            err_next     = rrt_pkg::ST_NOTREADY;
            hit_next     = 1'b0;
            hit_idx_next = '0;
            hit_tag_next = '0;
        end

        if (cmd.step)
        begin
            idx_next = idx_reg + 1'b1;
            if (op_reg == rrt_pkg::OP_INCOMING)
            begin
                // keep the last matching entry
                if (rd_type == msg_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg;
                    hit_tag_next = rd_tag;
                end
            end
            else
            begin
                // drop matches, move survivors down to the write pointer
                if (rd_type == msg_reg)
                begin
                    err_next = rd_code;
                    rem_next = rem_reg + 1'b1;
                end
                else
                begin
                    we_all  = 1'b1;
                    waddr   = wr_reg[IW-1:0];
                    wr_next = wr_reg + 1'b1;
                end
            end
        end

        if (cmd.finish)
        begin
            done_next    = 1'b1;
            status_next  = rrt_pkg::ST_NONE;
            send_next    = 1'b0;
            matched_next = 1'b0;
            mtag_next    = '0;
            droute_next  = 1'b0;
            dump_next    = 1'b0;
            case (op_reg)
                rrt_pkg::OP_INIT:
                begin
                    mode_next     = rrt_pkg::MODE_INIT;
                    pending_next  = '0;
                    answered_next = '0;
                end
                rrt_pkg::OP_SEND:
                begin
                    if (mode_reg != rrt_pkg::MODE_STARTUP)
                    begin
                        sent_next = msg_reg;
                        mode_next = rrt_pkg::MODE_SENT;
                        send_next = 1'b1;
                    end
                    else
                    begin
                        status_next = rrt_pkg::ST_NOTREADY;
                    end
                end
                rrt_pkg::OP_ACK:
                begin
                    if (mode_reg == rrt_pkg::MODE_SENT)
                    begin
                        mode_next = rrt_pkg::MODE_WAIT;
                    end
                end
                rrt_pkg::OP_WAIT:
                begin
                    if ((mode_reg == rrt_pkg::MODE_STARTUP)
                        || (mode_reg == rrt_pkg::MODE_RECV)
                        || (pending_reg >= MAX_CNT))
                    begin
                        status_next = rrt_pkg::ST_NOTREADY;
                    end
                    else
                    begin
                        we_all       = 1'b1;
                        waddr        = pending_reg[IW-1:0];
                        wtype        = msg_reg;
                        wtag         = tag_reg;
                        wcode        = rrt_pkg::ST_BUSY;
                        pending_next = pending_reg + 1'b1;
                    end
                end
                rrt_pkg::OP_INCOMING:
                begin
                    status_next  = inc_res;
                    matched_next = hit_reg;
                    mtag_next    = hit_reg ? hit_tag_reg : 8'd0;
                    if ((inc_res != rrt_pkg::ST_UNSOLICITED)
                        && (inc_res != rrt_pkg::ST_WAITING))
                    begin
                        dump_next = (inc_res == rrt_pkg::ST_UNHANDLED);
                        if (!handled_reg)
                        begin
                            droute_next = 1'b1;
                        end
                        else if (mode_reg == rrt_pkg::MODE_WAIT)
                        begin
                            if (hit_reg)
                            begin
                                we_code       = 1'b1;
                                waddr         = hit_idx_reg;
                                wcode         = inc_res;
                                answered_next = ans_inc;
                            end
                            if (KW'(answered_next) == KW'(pending_reg))
                            begin
                                mode_next = rrt_pkg::MODE_RECV;
                            end
                        end
                    end
                end
                rrt_pkg::OP_COLLECT:
                begin
                    if (mode_reg == rrt_pkg::MODE_INIT)
                    begin
                        status_next = rrt_pkg::ST_NONE;
                    end
                    else if (mode_reg != rrt_pkg::MODE_RECV)
                    begin
                        status_next = rrt_pkg::ST_NOTREADY;
                    end
                    else
                    begin
                        status_next   = err_reg;
                        answered_next = answered_reg - rrt_pkg::ANS_W'(rem_reg);
                        pending_next  = (pending_reg >= rem_reg) ? pending_reg - rem_reg : '0;
                        if (answered_next == '0)
                        begin
                            pending_next = '0;
                            mode_next    = rrt_pkg::MODE_INIT;
                        end
                    end
                end
                rrt_pkg::OP_RESET:
                begin
                    if (mode_reg != rrt_pkg::MODE_STARTUP)
                    begin
                        mode_next     = rrt_pkg::MODE_INIT;
                        pending_next  = '0;
                        answered_next = '0;
                    end
                end
                default:
                begin
                    status_next = rrt_pkg::ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_all)
        begin
            type_mem[waddr] <= wtype;
            tag_mem[waddr]  <= wtag;
            code_mem[waddr] <= wcode;
        end
        else if (we_code)
        begin
            code_mem[waddr] <= wcode;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rrt_pkg::MODE_STARTUP;
            pending_reg  <= '0;
            answered_reg <= '0;
            sent_reg     <= '0;
            done_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            rem_reg      <= '0;
            n_reg        <= '0;
        end
        else
        begin
            mode_reg     <= mode_next;
            pending_reg  <= pending_next;
            answered_reg <= answered_next;
            sent_reg     <= sent_next;
            done_reg     <= done_next;
            hit_reg      <= hit_next;
            idx_reg      <= idx_next;
            wr_reg       <= wr_next;
            rem_reg      <= rem_next;
            n_reg        <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        msg_reg     <= msg_next;
        tag_reg     <= tag_next;
        handled_reg <= handled_next;
        hcode_reg   <= hcode_next;
        err_reg     <= err_next;
        hit_idx_reg <= hit_idx_next;
        hit_tag_reg <= hit_tag_next;
        status_reg  <= status_next;
        send_reg    <= send_next;
        matched_reg <= matched_next;
        mtag_reg    <= mtag_next;
        droute_reg  <= droute_next;
        dump_reg    <= dump_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign mode_now       = 3'(mode_reg);
    assign send_strobe    = send_reg;
    assign matched        = matched_reg;
    assign matched_tag    = mtag_reg;
    assign default_route  = droute_reg;
    assign dump_request   = dump_reg;
    assign last_sent_type = sent_reg;

endmodule

>>> rtl/core/request_response_tracker_core.sv
// ----------------------------------------------------------------------------
// request_response_tracker_core - outstanding link request tracker
// Tracks the link mode and a table of awaited message types with their tags
// and handler outcomes; one result per event.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive op and its fields with start high; the beat is
//   taken at a rising edge where start is high and busy is low. busy rises
//   the cycle after and stays high until the result is out.
//   Result channel: done pulses high for exactly one cycle with status,
//   mode_now, the event flags and last_sent_type valid in that cycle. The
//   receiver cannot stall; sample the result when done is high.
//   Sequence: an event that needs no table walk goes from the accepting
//   edge straight to the finish state, which registers done. An incoming
//   frame in waiting mode walks pending-count entries, and a collect in
//   received mode walks the answered entries (up to MAX_PENDING), both
//   before the finish state, through the single table read port visited
//   once per cycle. busy holds off a new event until the last one is
//   through. A new beat may be taken in the same cycle that done is high.
//   Reset: rst_n low puts the mode in startup and clears the counters and
//   the last sent type. Table entries hold no reset value; only entries
//   below the pending count are ever read.
// ----------------------------------------------------------------------------
module request_response_tracker_core #(
    parameter int MAX_PENDING = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] op,
    input  logic [7:0] msg_type,
    input  logic [7:0] context_tag,
    input  logic       handled,
    input  logic [3:0] handler_code,
    output logic       done,
    output logic [3:0] status,
    output logic [2:0] mode_now,
    output logic       send_strobe,
    output logic       matched,
    output logic [7:0] matched_tag,
    output logic       default_route,
    output logic       dump_request,
    output logic [7:0] last_sent_type
);

    // command and status between sequencer and datapath
    rrt_pkg::cmd_t  cmd;
    rrt_pkg::stat_t stat;

    // sequencer: accept, walk the table, finish
    rrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath: table, mode, counters and result registers
    rrt_datapath #(
        .MAX_PENDING (MAX_PENDING)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (op),
        .msg_type       (msg_type),
        .context_tag    (context_tag),
        .handled        (handled),
        .handler_code   (handler_code),
        .done           (done),
        .status         (status),
        .mode_now       (mode_now),
        .send_strobe    (send_strobe),
        .matched        (matched),
        .matched_tag    (matched_tag),
        .default_route  (default_route),
        .dump_request   (dump_request),
        .last_sent_type (last_sent_type)
    );

endmodule

>>> tb/tracker_sb_pkg.sv
// ----------------------------------------------------------------------------
// tracker_sb_pkg - event/outcome types and scoreboard of the tracker bench
// Mirrors the link mode, the awaited-type table and the counters of the
// tracker, works out the outcome of every accepted event and checks the
// outcomes that come back from the block in order.
// ----------------------------------------------------------------------------
package tracker_sb_pkg;

    import rrt_pkg::*;

    localparam int         TABLE_DEPTH  = 4;
    localparam logic [2:0] OP_UNUSED    = 3'd7;
    localparam int         REPORT_LIMIT = 10;

    typedef struct {
        logic [2:0] op;
        logic [7:0] msg_type;
        logic [7:0] context_tag;
        logic       handled;
        logic [3:0] handler_code;
    } link_event_t;

    typedef struct {
        logic [3:0] status;
        logic [2:0] mode_now;
        logic       send_strobe;
        logic       matched;
        logic [7:0] matched_tag;
        logic       default_route;
        logic       dump_request;
        logic [7:0] last_sent_type;
    } link_outcome_t;

    class tracker_scoreboard;

        mode_t         mode;
        logic [7:0]    awaited_type [TABLE_DEPTH];
        logic [7:0]    awaited_tag  [TABLE_DEPTH];
        logic [3:0]    awaited_code [TABLE_DEPTH];
        int            pending;
        int            answered;
        logic [7:0]    sent_type;
        link_outcome_t outcome_q [$];
        int            error_count;

        function new();
            mode        = MODE_STARTUP;
            pending     = 0;
            answered    = 0;
            sent_type   = '0;
            error_count = 0;
            foreach (awaited_type[k])
            begin
                awaited_type[k] = '0;
                awaited_tag[k]  = '0;
                awaited_code[k] = '0;
            end
        endfunction

        function void reopen();
            mode     = MODE_INIT;
            pending  = 0;
            answered = 0;
        endfunction

        function int outstanding();
            return outcome_q.size();
        endfunction

        // advance the mirrored state by one event and queue its outcome
        function void note_event(link_event_t ev);
            link_outcome_t res;
            int            hit;
            int            i;
            int            j;
            logic [3:0]    code;

            res = '{default: '0};
            case (ev.op)
                OP_INIT: reopen();
                OP_SEND:
                begin
                    if (mode != MODE_STARTUP)
                    begin
                        sent_type       = ev.msg_type;
                        mode            = MODE_SENT;
                        res.send_strobe = 1'b1;
                    end
                    else
                        res.status = ST_NOTREADY;
                end
                OP_ACK:
                begin
                    if (mode == MODE_SENT)
                        mode = MODE_WAIT;
                end
                OP_WAIT:
                begin
                    if (mode == MODE_STARTUP || mode == MODE_RECV || pending >= TABLE_DEPTH)
                        res.status = ST_NOTREADY;
                    else
                    begin
                        awaited_type[pending] = ev.msg_type;
                        awaited_tag[pending]  = ev.context_tag;
                        awaited_code[pending] = ST_BUSY;
                        pending++;
                    end
                end
                OP_INCOMING:
                begin
                    hit  = -1;
                    code = ev.handled ? ev.handler_code : ST_INTERNAL;
                    // the last matching entry wins
                    if (mode == MODE_WAIT)
                        for (i = 0; i < pending && i < TABLE_DEPTH; i++)
                            if (awaited_type[i] == ev.msg_type)
                                hit = i;
                    if (hit >= 0)
                    begin
                        res.matched     = 1'b1;
                        res.matched_tag = awaited_tag[hit];
                    end
                    res.status = code;
                    if (code != ST_UNSOLICITED && code != ST_WAITING)
                    begin
                        if (code == ST_UNHANDLED)
                            res.dump_request = 1'b1;
                        if (!ev.handled)
                            res.default_route = 1'b1;
                        else if (mode == MODE_WAIT)
                        begin
                            if (hit >= 0)
                            begin
                                awaited_code[hit] = code;
                                if (answered < int'(ANS_MAX))
                                    answered++;
                            end
                            if (answered == pending)
                                mode = MODE_RECV;
                        end
                    end
                end
                OP_COLLECT:
                begin
                    if (mode == MODE_INIT)
                        res.status = ST_NONE;
                    else if (mode != MODE_RECV)
                        res.status = ST_NOTREADY;
                    else
                    begin
                        res.status = ST_NOTREADY;
                        i = 0;
                        while (i < answered && i < TABLE_DEPTH)
                        begin
                            if (awaited_type[i] == ev.msg_type)
                            begin
                                res.status = awaited_code[i];
                                for (j = i + 1; j < answered && j < TABLE_DEPTH; j++)
                                begin
                                    awaited_code[j - 1] = awaited_code[j];
                                    awaited_type[j - 1] = awaited_type[j];
                                    awaited_tag[j - 1]  = awaited_tag[j];
                                end
                                answered--;
                                if (pending > 0)
                                    pending--;
                            end
                            else
                                i++;
                        end
                        if (answered == 0)
                        begin
                            pending = 0;
                            mode    = MODE_INIT;
                        end
                    end
                end
                OP_RESET:
                begin
                    if (mode != MODE_STARTUP)
                        reopen();
                end
                default: ;
            endcase
            res.mode_now       = mode;
            res.last_sent_type = sent_type;
            outcome_q.push_back(res);
        endfunction

        // print one outcome on a single line behind a short label
        function void show_outcome(string label, link_outcome_t o);
            $write("  %s status=%0d mode=%0d send=%0b match=%0b ",
                   label, o.status, o.mode_now, o.send_strobe, o.matched);
            $display("tag=%02h route=%0b dump=%0b sent=%02h",
                     o.matched_tag, o.default_route, o.dump_request, o.last_sent_type);
        endfunction

        // compare one result beat with the oldest outstanding outcome
        function void check_result(link_outcome_t got);
            link_outcome_t want;

            if (outcome_q.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("ERROR: result beat with no event outstanding, status=%0d mode=%0d",
                             got.status, got.mode_now);
                return;
            end
            want = outcome_q.pop_front();
            if (got.status !== want.status || got.mode_now !== want.mode_now
                || got.send_strobe !== want.send_strobe || got.matched !== want.matched
                || got.matched_tag !== want.matched_tag
                || got.default_route !== want.default_route
                || got.dump_request !== want.dump_request
                || got.last_sent_type !== want.last_sent_type)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("ERROR: outcome mismatch");
                    show_outcome("exp", want);
                    show_outcome("got", got);
                end
            end
        endfunction

    endclass

endpackage

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of request_response_tracker_core
// Drives link events over the start/busy command port, mirrors the tracker
// in a scoreboard and checks every done beat field by field. A directed
// walk through the corner cases comes first, then random link exchanges
// (waits, send, ack, answers, collects) mixed with random noise events.
// ----------------------------------------------------------------------------
module tb_top;

    import rrt_pkg::*;
    import tracker_sb_pkg::*;

    // cycles with no accepted or done beat before the run is declared hung;
    // the slowest correct gap is the longest sender pause plus a full walk
    localparam int WATCHDOG_LIMIT = 400;
    // cycles to let pass once the last outcome is in
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 8;
    localparam int EVENT_TARGET   = 850;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [2:0] op;
    logic [7:0] msg_type;
    logic [7:0] context_tag;
    logic       handled;
    logic [3:0] handler_code;
    logic       done;
    logic [3:0] status;
    logic [2:0] mode_now;
    logic       send_strobe;
    logic       matched;
    logic [7:0] matched_tag;
    logic       default_route;
    logic       dump_request;
    logic [7:0] last_sent_type;

    tracker_scoreboard sb;
    int                events_sent;
    int                idle_cycles = 0;
    bit                steady;     // set: issue back to back, no sender pauses

    request_response_tracker_core #(
        .MAX_PENDING (TABLE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .msg_type       (msg_type),
        .context_tag    (context_tag),
        .handled        (handled),
        .handler_code   (handler_code),
        .done           (done),
        .status         (status),
        .mode_now       (mode_now),
        .send_strobe    (send_strobe),
        .matched        (matched),
        .matched_tag    (matched_tag),
        .default_route  (default_route),
        .dump_request   (dump_request),
        .last_sent_type (last_sent_type)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Sample every done beat at the rising edge and hand it to the scoreboard.
    always @(posedge clk)
    begin : result_monitor
        link_outcome_t got;

        if (rst_n && done)
        begin
            got.status         = status;
            got.mode_now       = mode_now;
            got.send_strobe    = send_strobe;
            got.matched        = matched;
            got.matched_tag    = matched_tag;
            got.default_route  = default_route;
            got.dump_request   = dump_request;
            got.last_sent_type = last_sent_type;
            sb.check_result(got);
        end
    end

    // Count cycles in which neither a command nor a result beat moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
            $display("request_response_tracker_core verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Handler outcome: mostly any code, now and then one of the special ones.
    function automatic logic [3:0] pick_code();
        if ($urandom_range(0, 5) == 0)
            return 4'($urandom_range(int'(ST_UNSOLICITED), int'(ST_UNHANDLED)));
        return 4'($urandom_range(0, 15));
    endfunction

    // Issue one command beat. Called at a falling edge; returns at the falling
    // edge after the beat is taken. Hold start high across back-to-back beats.
    task automatic issue_event(input logic [2:0] ev_op, input logic [7:0] ev_type,
                               input logic [7:0] ev_tag, input logic ev_handled,
                               input logic [3:0] ev_code);
        link_event_t ev;
        int          gap;

        ev.op           = ev_op;
        ev.msg_type     = ev_type;
        ev.context_tag  = ev_tag;
        ev.handled      = ev_handled;
        ev.handler_code = ev_code;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        = 1'b1;
        op           = ev_op;
        msg_type     = ev_type;
        context_tag  = ev_tag;
        handled      = ev_handled;
        handler_code = ev_code;
        // the beat goes in at the first rising edge that sees busy low
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_event(ev);
        events_sent++;
        @(negedge clk);
    endtask

    // Drop start and hold off until every outstanding outcome has come back.
    task automatic hold_until_drained();
        start = 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    // One well-formed exchange: open, register waits, send, ack, one answer
    // per registered wait, then collect. Types come from a small pool so
    // that duplicates hit the last-match and multi-remove paths. Now and then
    // the exchange is reopened after the answers and hammered with repeat
    // answers to push the answered counter into saturation.
    task automatic run_exchange();
        logic [7:0] pool       [3];
        logic [7:0] wait_types [TABLE_DEPTH + 1];
        int         waits;
        int         i;
        int         n;
        logic [7:0] t;

        foreach (pool[k])
            pool[k] = 8'($urandom);
        issue_event(($urandom_range(0, 1) != 0) ? OP_INIT : OP_RESET, 8'($urandom),
                    8'($urandom), 1'($urandom), 4'($urandom));
        waits = $urandom_range(0, TABLE_DEPTH + 1);
        for (i = 0; i < waits; i++)
        begin
            wait_types[i] = pool[$urandom_range(0, 2)];
            issue_event(OP_WAIT, wait_types[i], 8'($urandom), 1'($urandom), 4'($urandom));
        end
        issue_event(OP_SEND, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
        if ($urandom_range(0, 5) == 0)
            issue_event(OP_WAIT, pool[$urandom_range(0, 2)], 8'($urandom), 1'b0, 4'($urandom));
        issue_event(OP_ACK, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));

        // one answer per registered entry, with a stray frame now and then
        n = (waits > TABLE_DEPTH) ? TABLE_DEPTH : waits;
        for (i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                issue_event(OP_INCOMING, 8'($urandom), 8'($urandom), 1'($urandom), pick_code());
            t = wait_types[$urandom_range(0, n - 1)];
            issue_event(OP_INCOMING, t, 8'($urandom), ($urandom_range(0, 9) != 0), pick_code());
        end
        if (n == 0)
            issue_event(OP_INCOMING, pool[0], 8'($urandom), 1'b1, pick_code());

        // reopen and keep answering so the counter runs past the table size
        if (n > 0 && $urandom_range(0, 3) == 0)
        begin
            issue_event(OP_SEND, pool[1], 8'($urandom), 1'($urandom), 4'($urandom));
            issue_event(OP_ACK, 8'($urandom), 8'($urandom), 1'($urandom), 4'($urandom));
            repeat ($urandom_range(10, 16))
                issue_event(OP_INCOMING, wait_types[$urandom_range(0, n - 1)], 8'($urandom),
                            1'b1, 4'($urandom_range(7, 15)));
        end

        repeat (n + 1)
        begin
            t = ($urandom_range(0, 4) == 0) ? 8'($urandom) : pool[$urandom_range(0, 2)];
            issue_event(OP_COLLECT, t, 8'($urandom), 1'($urandom), 4'($urandom));
        end
    endtask

    // A short burst of fully random events, unused opcode included.
    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            issue_event(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                        4'($urandom));
    endtask

    initial
    begin
        sb           = new();
        events_sent  = 0;
        steady       = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_INIT;
        msg_type     = '0;
        context_tag  = '0;
        handled      = 1'b0;
        handler_code = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // startup: send and wait refused, ack and reset do nothing,
        // collect refused, unhandled frame routed to default, unused op
        issue_event(OP_SEND,     8'hFF, 8'h00, 1'b1, 4'hF);
        issue_event(OP_WAIT,     8'h11, 8'hAA, 1'b0, 4'h0);
        issue_event(OP_ACK,      8'h00, 8'h00, 1'b0, 4'h0);
        issue_event(OP_INCOMING, 8'h11, 8'h00, 1'b0, 4'h0);
        issue_event(OP_COLLECT,  8'h11, 8'h00, 1'b0, 4'h0);
        issue_event(OP_RESET,    8'h00, 8'h00, 1'b0, 4'h0);
        issue_event(OP_UNUSED,   8'hFF, 8'hFF, 1'b1, 4'hF);
        // initialised: collect returns none, then three waits, two of one type
        issue_event(OP_INIT,     8'h00, 8'h00, 1'b0, 4'h0);
        issue_event(OP_COLLECT,  8'h00, 8'h00, 1'b0, 4'h0);
        issue_event(OP_WAIT,     8'h00, 8'hFF, 1'b0, 4'h0);
        issue_event(OP_WAIT,     8'hFF, 8'h00, 1'b1, 4'hF);
        issue_event(OP_WAIT,     8'h00, 8'h5A, 1'b0, 4'h0);
        issue_event(OP_SEND,     8'hA5, 8'h00, 1'b0, 4'h0);
        issue_event(OP_ACK,      8'h00, 8'h00, 1'b0, 4'h0);
        // waiting: unsolicited and waiting outcomes end early, unhandled
        // outcome raises a dump, unhandled frame goes to the default handler
        issue_event(OP_INCOMING, 8'h00, 8'h00, 1'b1, ST_UNSOLICITED);
        issue_event(OP_INCOMING, 8'hFF, 8'h00, 1'b1, ST_WAITING);
        issue_event(OP_INCOMING, 8'h00, 8'h00, 1'b1, ST_UNHANDLED);
        issue_event(OP_INCOMING, 8'hFF, 8'h00, 1'b0, 4'hF);
        issue_event(OP_INCOMING, 8'h77, 8'h00, 1'b1, 4'hF);
        issue_event(OP_INCOMING, 8'hFF, 8'h00, 1'b1, 4'hF);
        issue_event(OP_INCOMING, 8'h00, 8'h00, 1'b1, 4'h0);
        // received: wait refused, collect of an absent type, then remove both
        // entries of one type, then the last entry back to initialised
        issue_event(OP_WAIT,     8'h42, 8'h42, 1'b0, 4'h0);
        issue_event(OP_COLLECT,  8'h42, 8'h00, 1'b0, 4'h0);
        issue_event(OP_COLLECT,  8'h00, 8'h00, 1'b0, 4'h0);
        issue_event(OP_COLLECT,  8'hFF, 8'h00, 1'b0, 4'h0);

        // hold off once with everything drained before the random part
        hold_until_drained();

        while (events_sent < EVENT_TARGET)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                run_noise();
            else
                run_exchange();
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("request_response_tracker_core verification clean");
        else
            $display("request_response_tracker_core verification failed");
        $finish;
    end

endmodule
